// File: src/assert_macros.svh
// assertion macros used by the checker file
// depends on nothing; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define SMDL_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SMDL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/smdl_pkg.sv
// shared types, constants and helper functions for the modulated delay line
// depends on nothing; used by the lane, merge, top and checker modules through scoped names
package smdl_pkg;

  localparam int STORE_DEPTH = 131072;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SAMPLE_BITS = 24;
  localparam int SINE_DEPTH  = 256;
  localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
  localparam int SINE_W      = 16;
  localparam int CNT_W       = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int ACC_W       = SAMPLE_BITS + 18;
  localparam int MOD_W       = SINE_W + 21;
  localparam int D_W         = ((ADDR_W + 8 > 25) ? ADDR_W + 8 : 25) + 3;
  localparam int FB_LIMIT    = 32440;
  localparam int FADE_FULL   = 65536;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t in_left;
    sample_t in_right;
  } in_beat_t;

  typedef struct packed {
    sample_t out_left;
    sample_t out_right;
  } out_beat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEEDBACK_GAIN = 3'd0,
    REG_WET_GAIN      = 3'd1,
    REG_DRY_GAIN      = 3'd2,
    REG_BASE_DELAY    = 3'd3,
    REG_LFO_DEPTH     = 3'd4,
    REG_LFO_STEP      = 3'd5,
    REG_DELAY_MODE    = 3'd6,
    REG_FADE_STEP     = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_DLY,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_DRY,
    ST_WET,
    ST_FB,
    ST_WRITE
  } seq_state_t;

  // per-step control from the sequencer to both lanes
  typedef struct packed {
    seq_state_t        step;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_ok;
    logic [7:0]        frac;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } lane_ctl_t;

  typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_DEPTH];

  // sin(pi/2 * u), u in Q30, result Q15
  function automatic logic signed [SINE_W-1:0] quarter_sine(input longint u);
    longint u2;
    longint s;
    longint r;
    u2 = (u * u) >>> 30;
    s  = 172272;
    s  = -5026996 + ((s * u2) >>> 30);
    s  = 85569306 + ((s * u2) >>> 30);
    s  = -693598668 + ((s * u2) >>> 30);
    s  = 1686629713 + ((s * u2) >>> 30);
    s  = (s * u) >>> 30;
    r  = (s + 16384) >>> 15;
    if (r < 0) r = 0;
    if (r > 32767) r = 32767;
    return SINE_W'(r);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint    q4;
    longint    quad;
    longint    rem;
    longint    u;
    logic signed [SINE_W-1:0] v;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      q4   = longint'(k) * 4;
      quad = q4 / SINE_DEPTH;
      rem  = q4 % SINE_DEPTH;
      u    = (rem <<< 30) / SINE_DEPTH;
      if (quad[0]) u = (longint'(1) <<< 30) - u;
      v = quarter_sine(u);
      tab[k] = (quad >= 2) ? -v : v;
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // saturate a wide signed value to the sample range
  function automatic sample_t sat_acc(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
    lo = -hi - ACC_W'(1);
    if (x > hi) return SAMPLE_BITS'(hi);
    if (x < lo) return SAMPLE_BITS'(lo);
    return SAMPLE_BITS'(x);
  endfunction

endpackage

// File: src/smdl_ram.sv
// generic single-port-write, single-port-read ram with registered read
// depends on nothing
module smdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/smdl_lane.sv
// one channel lane: sample store, interpolated tap read, mix, feedback and inject products
// depends on smdl_pkg and smdl_ram
module smdl_lane (
  input  logic                clk,
  input  smdl_pkg::lane_ctl_t ctl,
  input  smdl_pkg::sample_t   in_sample,
  input  logic [15:0]         dry_gain,
  input  logic [15:0]         wet_scale,
  input  logic [14:0]         fb_gain,
  input  smdl_pkg::sample_t   wr_data,
  output smdl_pkg::sample_t   fb_term,
  output smdl_pkg::sample_t   inject,
  output smdl_pkg::sample_t   mix_out
);

  localparam int SB = smdl_pkg::SAMPLE_BITS;

  logic [SB-1:0]           rd_data;
  logic                    ok_r;
  smdl_pkg::sample_t       a_r;
  smdl_pkg::sample_t       dl_r;
  logic signed [SB+16:0]   p_dry_r;
  logic signed [SB+16:0]   p_wet_r;
  smdl_pkg::sample_t       fb_term_r;
  smdl_pkg::sample_t       inject_r;
  smdl_pkg::sample_t       mix_r;

  smdl_pkg::sample_t       b_val;
  logic signed [SB:0]      diff;
  logic signed [SB+9:0]    ip;
  logic signed [SB+9:0]    dl_wide;
  logic signed [SB+15:0]   fb_prod;
  logic signed [16:0]      inj_gain;
  logic signed [SB+17:0]   inj_prod;
  logic signed [SB+17:0]   mix_sum;

  smdl_ram #(
    .WIDTH (SB),
    .DEPTH (smdl_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (ctl.wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (ctl.rd_addr),
    .rd_data (rd_data)
  );

  // datapath arithmetic for the interpolation, feedback, inject and mix terms
  always_comb begin
    b_val    = ok_r ? smdl_pkg::sample_t'(rd_data) : '0;
    diff     = (SB+1)'(b_val) - (SB+1)'(a_r);
    ip       = diff * $signed({1'b0, ctl.frac});
    dl_wide  = (SB+10)'(a_r) + (ip >>> 8);
    fb_prod  = dl_r * $signed({1'b0, fb_gain});
    inj_gain = 17'(18'sd32768 - 18'($signed({1'b0, fb_gain})));
    inj_prod = in_sample * inj_gain;
    mix_sum  = (SB+18)'(p_dry_r) + (SB+18)'(p_wet_r);
  end

  // step registers
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      ok_r <= ctl.rd_ok;
    end
    unique case (ctl.step)
      smdl_pkg::ST_RD1: begin
        a_r <= b_val;
      end
      smdl_pkg::ST_INTERP: begin
        dl_r <= smdl_pkg::sample_t'(dl_wide);
      end
      smdl_pkg::ST_DRY: begin
        p_dry_r <= $signed({1'b0, dry_gain}) * in_sample;
      end
      smdl_pkg::ST_WET: begin
        p_wet_r <= $signed({1'b0, wet_scale}) * dl_r;
      end
      smdl_pkg::ST_FB: begin
        fb_term_r <= smdl_pkg::sample_t'(fb_prod >>> 15);
        inject_r  <= smdl_pkg::sample_t'(inj_prod >>> 15);
        mix_r     <= smdl_pkg::sat_acc(smdl_pkg::ACC_W'(mix_sum >>> 15));
      end
      default: begin
      end
    endcase
  end

  assign fb_term = fb_term_r;
  assign inject  = inject_r;
  assign mix_out = mix_r;

endmodule

// File: src/smdl_merge.sv
// merging stage: routes input and feedback between lanes, saturates store writes and forms the output beat
// depends on smdl_pkg
module smdl_merge (
  input  logic                delay_mode,
  input  logic                cross_flip,
  input  smdl_pkg::in_beat_t  in_beat,
  input  smdl_pkg::sample_t   fb_left,
  input  smdl_pkg::sample_t   fb_right,
  input  smdl_pkg::sample_t   inject_left,
  input  smdl_pkg::sample_t   mix_left,
  input  smdl_pkg::sample_t   mix_right,
  output smdl_pkg::sample_t   wr_left,
  output smdl_pkg::sample_t   wr_right,
  output smdl_pkg::out_beat_t out_beat
);

  localparam int AW = smdl_pkg::ACC_W;

  logic signed [AW-1:0] sum_l;
  logic signed [AW-1:0] sum_r;

  // normal mode keeps each channel on itself, ping-pong crosses over
  always_comb begin
    if (delay_mode) begin
      sum_l = AW'(inject_left) + (cross_flip ? '0 : AW'(fb_right));
      sum_r = cross_flip ? AW'(fb_left) : '0;
    end else begin
      sum_l = AW'(in_beat.in_left) + AW'(fb_left);
      sum_r = AW'(in_beat.in_right) + AW'(fb_right);
    end
    wr_left            = smdl_pkg::sat_acc(sum_l);
    wr_right           = smdl_pkg::sat_acc(sum_r);
    out_beat.out_left  = mix_left;
    out_beat.out_right = mix_right;
  end

endmodule

// File: src/stereo_modulated_delay_line.sv
// a result is registered at the write-back step, which holds while an earlier result is still stalled;
// the step sequencer takes each stereo beat through modulation, delay, two store reads per lane,
// interpolation, mix and feedback products and write-back, and takes no new beat until it is done
// reset: synchronous active-low; clears control state and config to defaults,
// store entries not yet written since reset read as zero via a fill pointer
module stereo_modulated_delay_line (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  smdl_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output smdl_pkg::out_beat_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smdl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smdl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = smdl_pkg::ADDR_W;
  localparam int DW = smdl_pkg::D_W;
  localparam logic signed [DW-1:0] D_MIN = DW'(256);
  localparam logic signed [DW-1:0] D_MAX = DW'((smdl_pkg::STORE_DEPTH - 2) * 256);

  smdl_pkg::seq_state_t state_r, state_nxt;

  // configuration
  logic [14:0] fb_gain_r;
  logic [15:0] wet_gain_r;
  logic [15:0] dry_gain_r;
  logic [24:0] base_delay_r;
  logic [19:0] lfo_depth_r;
  logic [31:0] lfo_step_r;
  logic        delay_mode_r;
  logic [16:0] fade_step_r;

  // running state
  logic [AW-1:0]                 wp_r;
  logic                          wrapped_r;
  logic [31:0]                   phase_r;
  logic [16:0]                   fade_r;
  logic                          flip_r;
  logic [smdl_pkg::CNT_W-1:0]    cnt_r;

  // per-beat registers
  smdl_pkg::in_beat_t            in_r;
  logic signed [smdl_pkg::MOD_W-1:0] mod_r;
  logic [15:0]                   wscale_r;
  logic [AW-1:0]                 i0_r;
  logic [7:0]                    frac_r;
  logic [smdl_pkg::CNT_W-1:0]    reload_r;
  smdl_pkg::out_beat_t           out_r;
  logic                          out_valid_r;

  logic                          in_fire;
  logic                          cfg_fire;
  logic                          commit;
  logic [14:0]                   fb_eff;
  logic signed [DW-1:0]          d8;
  logic signed [DW-1:0]          d8c;
  logic [AW+7:0]                 rp;
  logic [32:0]                   wprod;
  logic [17:0]                   fade_sum;
  smdl_pkg::lane_ctl_t           ctl;
  smdl_pkg::sample_t             fb_l, fb_r, inj_l, inj_r, mix_l, mix_r, wr_l, wr_r;
  smdl_pkg::out_beat_t           merged;

  assign in_ready  = (state_r == smdl_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fb_eff    = (fb_gain_r > 15'(smdl_pkg::FB_LIMIT)) ? 15'(smdl_pkg::FB_LIMIT)
                                                           : fb_gain_r;

  // sequencer next state and lane control
  always_comb begin
    state_nxt   = state_r;
    commit      = 1'b0;
    ctl.step    = state_r;
    ctl.rd_en   = 1'b0;
    ctl.rd_addr = i0_r;
    ctl.frac    = frac_r;
    ctl.wr_addr = wp_r;
    unique case (state_r)
      smdl_pkg::ST_IDLE:   if (in_fire) state_nxt = smdl_pkg::ST_MOD;
      smdl_pkg::ST_MOD:    state_nxt = smdl_pkg::ST_DLY;
      smdl_pkg::ST_DLY:    state_nxt = smdl_pkg::ST_RD0;
      smdl_pkg::ST_RD0: begin
        ctl.rd_en = 1'b1;
        state_nxt = smdl_pkg::ST_RD1;
      end
      smdl_pkg::ST_RD1: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = i0_r + AW'(1);
        state_nxt   = smdl_pkg::ST_INTERP;
      end
      smdl_pkg::ST_INTERP: state_nxt = smdl_pkg::ST_DRY;
      smdl_pkg::ST_DRY:    state_nxt = smdl_pkg::ST_WET;
      smdl_pkg::ST_WET:    state_nxt = smdl_pkg::ST_FB;
      smdl_pkg::ST_FB:     state_nxt = smdl_pkg::ST_WRITE;
      smdl_pkg::ST_WRITE: begin
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = smdl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = smdl_pkg::ST_IDLE;
    endcase
    ctl.rd_ok = wrapped_r || (ctl.rd_addr < wp_r);
    ctl.wr_en = commit;
  end

  // delay, wet scale and fade arithmetic
  always_comb begin
    d8 = DW'($signed({1'b0, base_delay_r})) + DW'(mod_r >>> 15);
    if (d8 < D_MIN) d8c = D_MIN;
    else if (d8 > D_MAX) d8c = D_MAX;
    else d8c = d8;
    rp       = {wp_r, 8'd0} - d8c[AW+7:0];
    wprod    = wet_gain_r * fade_r;
    fade_sum = 18'(fade_r) + 18'(fade_step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smdl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // per-beat datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (state_r == smdl_pkg::ST_MOD) begin
      mod_r    <= smdl_pkg::SINE_TAB[phase_r[31 -: smdl_pkg::SINE_IDX_W]] *
                  $signed({1'b0, lfo_depth_r});
      wscale_r <= wprod[31:16];
    end
    if (state_r == smdl_pkg::ST_DLY) begin
      i0_r     <= rp[AW+7:8];
      frac_r   <= rp[7:0];
      reload_r <= d8c[smdl_pkg::CNT_W+7:8];
    end
    if (commit) begin
      out_r <= merged;
    end
  end

  // control state, configuration and beat bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_gain_r    <= '0;
      wet_gain_r   <= 16'd16384;
      dry_gain_r   <= 16'd32768;
      base_delay_r <= 25'd5644800;
      lfo_depth_r  <= '0;
      lfo_step_r   <= '0;
      delay_mode_r <= 1'b0;
      fade_step_r  <= 17'd74;
      wp_r         <= '0;
      wrapped_r    <= 1'b0;
      phase_r      <= '0;
      fade_r       <= '0;
      flip_r       <= 1'b0;
      cnt_r        <= smdl_pkg::CNT_W'(25'd5644800 >> 8);
      out_valid_r  <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (commit) begin
        wp_r    <= wp_r + AW'(1);
        if (wp_r == AW'(smdl_pkg::STORE_DEPTH - 1)) wrapped_r <= 1'b1;
        phase_r <= phase_r + lfo_step_r;
        fade_r  <= (fade_sum > 18'(smdl_pkg::FADE_FULL)) ? 17'(smdl_pkg::FADE_FULL)
                                                          : fade_sum[16:0];
        if (delay_mode_r) begin
          if (cnt_r <= smdl_pkg::CNT_W'(1)) begin
            flip_r <= ~flip_r;
            cnt_r  <= reload_r;
          end else begin
            cnt_r <= cnt_r - smdl_pkg::CNT_W'(1);
          end
        end
      end
      if (cfg_fire) begin
        unique case (smdl_pkg::cfg_reg_t'(cfg_index))
          smdl_pkg::REG_FEEDBACK_GAIN: fb_gain_r   <= cfg_data[14:0];
          smdl_pkg::REG_WET_GAIN:      wet_gain_r  <= cfg_data[15:0];
          smdl_pkg::REG_DRY_GAIN:      dry_gain_r  <= cfg_data[15:0];
          smdl_pkg::REG_BASE_DELAY: begin
            base_delay_r <= cfg_data[24:0];
            if (cfg_data[24:0] != base_delay_r) cnt_r <= cfg_data[24:8];
          end
          smdl_pkg::REG_LFO_DEPTH:     lfo_depth_r  <= cfg_data[19:0];
          smdl_pkg::REG_LFO_STEP:      lfo_step_r   <= cfg_data[31:0];
          smdl_pkg::REG_DELAY_MODE:    delay_mode_r <= cfg_data[0];
          smdl_pkg::REG_FADE_STEP:     fade_step_r  <= cfg_data[16:0];
          default: begin
          end
        endcase
      end
    end
  end

  // left and right lanes
  smdl_lane u_lane_left (
    .clk       (clk),
    .ctl       (ctl),
    .in_sample (in_r.in_left),
    .dry_gain  (dry_gain_r),
    .wet_scale (wscale_r),
    .fb_gain   (fb_eff),
    .wr_data   (wr_l),
    .fb_term   (fb_l),
    .inject    (inj_l),
    .mix_out   (mix_l)
  );

  smdl_lane u_lane_right (
    .clk       (clk),
    .ctl       (ctl),
    .in_sample (in_r.in_right),
    .dry_gain  (dry_gain_r),
    .wet_scale (wscale_r),
    .fb_gain   (fb_eff),
    .wr_data   (wr_r),
    .fb_term   (fb_r),
    .inject    (inj_r),
    .mix_out   (mix_r)
  );

  // right lane inject term is unused by the routing, left lane carries the input
  smdl_merge u_merge (
    .delay_mode  (delay_mode_r),
    .cross_flip  (flip_r),
    .in_beat     (in_r),
    .fb_left     (fb_l),
    .fb_right    (fb_r),
    .inject_left (delay_mode_r ? inj_l : inj_r),
    .mix_left    (mix_l),
    .mix_right   (mix_r),
    .wr_left     (wr_l),
    .wr_right    (wr_r),
    .out_beat    (merged)
  );

endmodule

// File: src/smdl_checker.sv
// port-level checker for the modulated delay line, bound to the top level
// depends on smdl_pkg and assert_macros.svh
`include "assert_macros.svh"

module smdl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input smdl_pkg::out_beat_t out_data,
  input logic                cfg_ready
);

  // a stalled result beat stays offered
  `SMDL_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out beat dropped")

  // one beat in flight: input closes right after a beat is taken
  `SMDL_ASSERT_RST(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready, "second beat taken")

  // a result never appears the cycle after its input beat
  `SMDL_ASSERT_RST(a_no_early, clk, rst_n, in_valid && in_ready |=> !$rose(out_valid), "early result")

  // the config port never stalls
  `SMDL_ASSERT_RST(a_cfg_open, clk, rst_n, $past(rst_n) |-> cfg_ready, "cfg stalled")

  // a stalled result keeps its payload
  `SMDL_ASSERT_RST(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_data), "payload moved")

endmodule

bind stereo_modulated_delay_line smdl_checker u_smdl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
